### src/dts_pkg.sv
package dts_pkg;

  // Default number of fraction bits in the depth value (1.0 = 1 << bits)
  localparam int DEPTH_FRAC_BITS_DEF = 16;

  localparam int CH_W    = 8;
  localparam int COLOR_W = 3 * CH_W;

  // Square root datapath: radicand is at most 17 bits, so 9 result bits
  localparam int SQ_W            = 18;
  localparam int SQRT_STEPS      = 9;
  localparam int STEPS_PER_STAGE = 3;
  localparam int SQ_STAGES       = SQRT_STEPS / STEPS_PER_STAGE;

  localparam logic [COLOR_W-1:0] GLASS_TINT_RESET = 24'hB0B080;
  localparam logic [CH_W:0]      CH_MAX           = 9'h0FF;

  // Item moving through the square root stages
  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } sq_item_t;

  // Glass blend: pixel/2 + tint/4, saturated
  function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] pix,
                                                    input logic [CH_W-1:0] tint);
    logic [CH_W:0] sum;
    sum = {2'b00, pix[CH_W-1:1]} + {3'b000, tint[CH_W-1:2]};
    blend_channel = (sum > CH_MAX) ? {CH_W{1'b1}} : sum[CH_W-1:0];
  endfunction

endpackage

### src/dts_mult.sv
// Front of the pipeline: blend, then products for all three channels.
// Three register stages; output is the radicand for red plus final green/blue.
module dts_mult #(
  parameter int DEPTH_FRAC_BITS = dts_pkg::DEPTH_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dts_pkg::COLOR_W-1:0]  glass_tint,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dts_pkg::COLOR_W-1:0]  pixel_color,
  input  logic [DEPTH_FRAC_BITS:0]     depth_fraction,
  input  logic                         glass_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dts_pkg::sq_item_t            out_item
);

  localparam int DW  = DEPTH_FRAC_BITS + 1;
  localparam int CW  = dts_pkg::CH_W;
  localparam int RRW = 2 * CW;
  localparam int GDW = DW + CW;
  localparam int DDW = 2 * DW;
  localparam int RDW = RRW + DW;
  localparam int BDW = DDW + CW;

  // stage valids and ready chain
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // stage 1: channel split and glass blend
  logic [CW-1:0] r_in, g_in, b_in;
  logic [CW-1:0] r1, g1, b1;
  logic [DW-1:0] d1;

  always_comb begin
    r_in = pixel_color[3*CW-1:2*CW];
    g_in = pixel_color[2*CW-1:CW];
    b_in = pixel_color[CW-1:0];
    if (glass_mode) begin
      r_in = dts_pkg::blend_channel(r_in, glass_tint[3*CW-1:2*CW]);
      g_in = dts_pkg::blend_channel(g_in, glass_tint[2*CW-1:CW]);
      b_in = dts_pkg::blend_channel(b_in, glass_tint[CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      r1 <= r_in;
      g1 <= g_in;
      b1 <= b_in;
      d1 <= depth_fraction;
    end
  end

  // stage 2: r*r, g*d, d*d
  logic [RRW-1:0] rr2;
  logic [GDW-1:0] gd2;
  logic [DDW-1:0] dd2;
  logic [CW-1:0]  b2;
  logic [DW-1:0]  d2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rr2 <= RRW'(r1) * RRW'(r1);
      gd2 <= GDW'(g1) * GDW'(d1);
      dd2 <= DDW'(d1) * DDW'(d1);
      b2  <= b1;
      d2  <= d1;
    end
  end

  // stage 3: r*r*d and b*d*d, truncate to the kept bits
  logic [RDW-1:0] rrd;
  logic [BDW-1:0] bdd;

  assign rrd = RDW'(rr2) * RDW'(d2);
  assign bdd = BDW'(b2) * BDW'(dd2);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_item.rem   <= dts_pkg::SQ_W'(rrd[RDW-1:DEPTH_FRAC_BITS]);
      out_item.root  <= '0;
      out_item.green <= gd2[DEPTH_FRAC_BITS+CW-1:DEPTH_FRAC_BITS];
      out_item.blue  <= bdd[2*DEPTH_FRAC_BITS+CW-1:2*DEPTH_FRAC_BITS];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

endmodule

### src/dts_sqrt_stage.sv
// One register stage of the digit-by-digit integer square root.
module dts_sqrt_stage #(
  parameter int STAGE_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dts_pkg::sq_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output dts_pkg::sq_item_t out_item
);

  localparam int SW = dts_pkg::SQ_W;

  dts_pkg::sq_item_t item_next;

  // a few root digits per stage; bit position is fixed per step
  always_comb begin
    logic [SW-1:0] bit_val;
    logic [SW-1:0] trial;
    item_next = in_item;
    for (int k = 0; k < dts_pkg::STEPS_PER_STAGE; k++) begin
      bit_val = SW'(1) << (2 * (dts_pkg::SQRT_STEPS - 1
                                - (STAGE_INDEX * dts_pkg::STEPS_PER_STAGE + k)));
      trial = item_next.root + bit_val;
      if (item_next.rem >= trial) begin
        item_next.rem  = item_next.rem - trial;
        item_next.root = (item_next.root >> 1) + bit_val;
      end else begin
        item_next.root = item_next.root >> 1;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

endmodule

### src/depth_tint_shader.sv
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    pixel_color, depth_fraction, glass_mode
// out       out  out_valid / out_ready  shaded_color
// cfg       in   cfg_valid / cfg_ready  glass_tint (always ready)
//
// Takes one pixel request per clock while not stalled; stages are blend and two
// multiply stages, then three square root stages of three digits each for red.
// Reset (rst, synchronous) empties the pipeline and loads the tint reset value.
// Stalls hold every full stage; a stage fills whenever it is empty or the one after it has room.
module depth_tint_shader #(
  parameter int DEPTH_FRAC_BITS = dts_pkg::DEPTH_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dts_pkg::COLOR_W-1:0] glass_tint,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dts_pkg::COLOR_W-1:0] pixel_color,
  input  logic [DEPTH_FRAC_BITS:0]    depth_fraction,
  input  logic                        glass_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dts_pkg::COLOR_W-1:0] shaded_color
);

  localparam int NS = dts_pkg::SQ_STAGES;
  localparam int CW = dts_pkg::CH_W;

  // tint register
  logic [dts_pkg::COLOR_W-1:0] tint;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tint <= dts_pkg::GLASS_TINT_RESET;
    end else if (cfg_valid) begin
      tint <= glass_tint;
    end
  end

  // links between pipeline sections
  logic              lk_valid [NS+1];
  logic              lk_ready [NS+1];
  dts_pkg::sq_item_t lk_item  [NS+1];

  dts_mult #(
    .DEPTH_FRAC_BITS(DEPTH_FRAC_BITS)
  ) u_mult (
    .clk           (clk),
    .rst           (rst),
    .glass_tint    (tint),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_color   (pixel_color),
    .depth_fraction(depth_fraction),
    .glass_mode    (glass_mode),
    .out_valid     (lk_valid[0]),
    .out_ready     (lk_ready[0]),
    .out_item      (lk_item[0])
  );

  // square root stages for red
  for (genvar s = 0; s < NS; s++) begin : g_sqrt
    dts_sqrt_stage #(
      .STAGE_INDEX(s)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (lk_valid[s]),
      .in_ready (lk_ready[s]),
      .in_item  (lk_item[s]),
      .out_valid(lk_valid[s+1]),
      .out_ready(lk_ready[s+1]),
      .out_item (lk_item[s+1])
    );
  end

  assign out_valid    = lk_valid[NS];
  assign lk_ready[NS] = out_ready;
  assign shaded_color = {lk_item[NS].root[CW-1:0], lk_item[NS].green, lk_item[NS].blue};

endmodule
